/* rtl/assert_macros.svh */
// Assertion macros used by the checker rfd_checker.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("check failed");
`endif

/* rtl/rfd_pkg.sv */
// Package for radial_fog_depth: widths, register indexes, state codes, multiplier types.
// Depends on nothing.
package rfd_pkg;
    localparam int FRAC_BITS = 12;
    localparam int NUM_ELEMS = 12;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_NEAR   = 2'd1;
    localparam logic [1:0] REG_FAR    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_LOAD, ST_MUL_RUN, ST_ACC, ST_SQ_LOAD, ST_SQ_RUN, ST_SQRT_LOAD,
        ST_SQRT_RUN, ST_NUM_LOAD, ST_NUM_RUN, ST_DIV_LOAD, ST_DIV_RUN, ST_DONE
    } state_t;

    // Multiplier request and answer
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;
endpackage

/* rtl/rfd_mul.sv */
// Shift-add multiplier, unsigned 32x32, one multiplier bit per cycle.
// Depends on rfd_pkg.
module rfd_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  rfd_pkg::mul_req_t req,
    output rfd_pkg::mul_rsp_t rsp
);
    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    // one bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg   <= 1'b1;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                mcand_reg  <= {32'd0, req.a};
                mplier_reg <= req.b;
            end else if (busy_reg) begin
                if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[62:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[31:1]};
                cnt_reg    <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule

/* rtl/rfd_sqrt.sv */
// Digit-by-digit square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing.
module rfd_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] trial;
    logic [33:0] rem_sh;

    // shift in two bits, try 4*root+1
    assign rem_sh = {rem_reg[31:0], rad_reg[63:62]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/rfd_div.sv */
// Restoring divider, unsigned 64/32, one quotient bit per cycle.
// Depends on nothing.
module rfd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;

    assign rem_sh = {rem_reg[31:0], quo_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (rem_sh >= {1'b0, dsr_reg}) begin
                    rem_reg <= rem_sh - {1'b0, dsr_reg};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* rtl/radial_fog_depth.sv */
// Radial fog depth: one request per vertex gives w = distance to the camera and its
// perspective depth z. Load requests write the view matrix and give no result, one
// per cycle while no result waits at a stalled output. A vertex goes through nine
// transform products and three squares, bit-serially through one shared multiplier,
// then a two-bit-per-cycle square root, the distance-by-(near+far) product and a
// one-bit-per-cycle 64/32 divider, which is skipped when near equals far. No request
// is taken while a vertex is in progress. A disabled vertex gives its result in the
// cycle after acceptance.
// Depends on rfd_pkg, rfd_mul, rfd_sqrt, rfd_div.
module radial_fog_depth (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,     // action
    input  logic [199:0] s_tdata,     // elem_index, elem_value, vx, vy, vz, pass_z, pass_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,     // plane_error
    output logic [63:0]  m_tdata,     // fog_z, fog_w
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int FB = rfd_pkg::FRAC_BITS;

    logic [31:0] mat_reg [rfd_pkg::NUM_ELEMS];
    logic        enable_reg;
    logic [15:0] near_reg, far_reg;

    rfd_pkg::state_t state_reg, state_next;
    logic [31:0] v_reg [3];
    logic [1:0]  col_reg, row_reg;
    logic signed [53:0] d_reg [3];
    logic [65:0] sum_reg;
    logic [31:0] dist_reg;
    logic        neg_reg;
    logic [63:0] num_reg;
    logic [31:0] oz_reg, ow_reg;
    logic        oerr_reg, ovalid_reg;

    rfd_pkg::mul_req_t mreq;
    rfd_pkg::mul_rsp_t mrsp;
    logic sq_start, sq_done, dv_start, dv_done;
    logic [31:0] sq_root;
    logic [63:0] dv_quo;

    rfd_mul u_mul (.aclk, .aresetn, .req(mreq), .rsp(mrsp));
    rfd_sqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .radicand(sum_reg[63:0]),
        .done(sq_done), .root(sq_root));

    // Operand selection for the shared multiplier
    logic [31:0] ma, mb, mabs_a, mabs_b;
    logic [3:0]  midx;
    logic [53:0] dabs;
    logic [31:0] dclamp;
    assign midx   = 4'({2'b00, row_reg} * 4'd3 + {2'b00, col_reg});
    assign ma     = v_reg[row_reg];
    assign mb     = mat_reg[midx];
    assign mabs_a = ma[31] ? 32'(-ma) : ma;
    assign mabs_b = mb[31] ? 32'(-mb) : mb;
    assign dabs   = d_reg[col_reg][53] ? 54'(-d_reg[col_reg]) : 54'(d_reg[col_reg]);
    // magnitude clamped to 2^31; its square 2^62 comes from the multiplier
    assign dclamp = (dabs >= 54'h80000000) ? 32'h80000000 : dabs[31:0];

    // Signed product, floored
    logic signed [64:0] sprod;
    logic signed [64:0] sfloor;
    assign sprod  = neg_reg ? -$signed({1'b0, mrsp.prod}) : $signed({1'b0, mrsp.prod});
    assign sfloor = sprod >>> FB;

    // Depth numerator: 2*n*f<<FB - dist*(n+f), dividend magnitude and sign
    logic [16:0] nf_sum;
    logic [32:0] nf_prod;
    logic signed [66:0] num_s;
    logic [63:0] dv_mag;
    logic        num_neg, den_neg, den_zero;
    logic [16:0] den_abs;
    assign nf_sum  = {1'b0, near_reg} + {1'b0, far_reg};
    assign nf_prod = {32'(near_reg) * 32'(far_reg), 1'b0};
    assign num_s   = $signed({34'd0, nf_prod} << FB) - $signed({3'd0, num_reg});
    assign num_neg = num_s[66];
    assign dv_mag  = num_neg ? 64'(-num_s) : num_s[63:0];
    assign den_zero = (near_reg == far_reg);
    assign den_neg  = near_reg < far_reg;
    assign den_abs  = den_neg ? 17'({1'b0, far_reg} - {1'b0, near_reg})
                              : 17'({1'b0, near_reg} - {1'b0, far_reg});

    rfd_div u_div (.aclk, .aresetn, .start(dv_start), .dividend(dv_mag),
        .divisor({15'd0, den_abs}), .done(dv_done), .quotient(dv_quo));

    // Signed quotient with saturation
    logic        qneg;
    logic [31:0] zsat;
    assign qneg = num_neg ^ den_neg;
    always_comb begin
        if (qneg) zsat = (dv_quo > 64'h80000000) ? 32'h80000000 : 32'(-dv_quo);
        else      zsat = (dv_quo > 64'h7FFFFFFF) ? 32'h7FFFFFFF : dv_quo[31:0];
    end

    logic in_acc, out_free;
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == rfd_pkg::ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Next state and unit starts
    always_comb begin
        state_next = state_reg;
        mreq.start = 1'b0;
        mreq.a     = mabs_a;
        mreq.b     = mabs_b;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        unique case (state_reg)
            rfd_pkg::ST_IDLE:
                if (in_acc && s_tuser && enable_reg) state_next = rfd_pkg::ST_MUL_LOAD;
            rfd_pkg::ST_MUL_LOAD: begin
                mreq.start = 1'b1;
                state_next = rfd_pkg::ST_MUL_RUN;
            end
            rfd_pkg::ST_MUL_RUN:
                if (mrsp.done) state_next = rfd_pkg::ST_ACC;
            rfd_pkg::ST_ACC:
                if (row_reg == 2'd2 && col_reg == 2'd2) state_next = rfd_pkg::ST_SQ_LOAD;
                else state_next = rfd_pkg::ST_MUL_LOAD;
            rfd_pkg::ST_SQ_LOAD: begin
                mreq.start = 1'b1;
                mreq.a     = dclamp;
                mreq.b     = dclamp;
                state_next = rfd_pkg::ST_SQ_RUN;
            end
            rfd_pkg::ST_SQ_RUN:
                if (mrsp.done) begin
                    if (col_reg == 2'd2) state_next = rfd_pkg::ST_SQRT_LOAD;
                    else state_next = rfd_pkg::ST_SQ_LOAD;
                end
            // sum of squares is complete here; sqrt of the low 64 bits
            rfd_pkg::ST_SQRT_LOAD: begin
                sq_start   = 1'b1;
                state_next = rfd_pkg::ST_SQRT_RUN;
            end
            rfd_pkg::ST_SQRT_RUN:
                if (sq_done) state_next = rfd_pkg::ST_NUM_LOAD;
            rfd_pkg::ST_NUM_LOAD: begin
                mreq.start = 1'b1;
                mreq.a     = dist_reg;
                mreq.b     = {15'd0, nf_sum};
                state_next = rfd_pkg::ST_NUM_RUN;
            end
            rfd_pkg::ST_NUM_RUN:
                if (mrsp.done) state_next = rfd_pkg::ST_DIV_LOAD;
            rfd_pkg::ST_DIV_LOAD: begin
                if (den_zero) state_next = rfd_pkg::ST_DONE;
                else begin
                    dv_start   = 1'b1;
                    state_next = rfd_pkg::ST_DIV_RUN;
                end
            end
            rfd_pkg::ST_DIV_RUN:
                if (dv_done) state_next = rfd_pkg::ST_DONE;
            rfd_pkg::ST_DONE:
                if (out_free) state_next = rfd_pkg::ST_IDLE;
            default: state_next = rfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rfd_pkg::ST_IDLE;
            enable_reg <= 1'b1;
            near_reg   <= 16'd100;
            far_reg    <= 16'd20000;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    rfd_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                    rfd_pkg::REG_NEAR:   near_reg   <= cfg_data;
                    rfd_pkg::REG_FAR:    far_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && s_tuser && !enable_reg) begin
                ovalid_reg <= 1'b1;
                oz_reg     <= s_tdata[163:132];
                ow_reg     <= s_tdata[195:164];
                oerr_reg   <= 1'b0;
            end else if (state_reg == rfd_pkg::ST_DONE && out_free) begin
                ovalid_reg <= 1'b1;
                ow_reg     <= dist_reg;
                oerr_reg   <= den_zero;
                if (den_zero) oz_reg <= num_neg ? 32'h80000000 : 32'h7FFFFFFF;
                else          oz_reg <= zsat;
            end else if (m_tvalid && m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc && !s_tuser && s_tdata[3:0] < 4'(rfd_pkg::NUM_ELEMS))
            mat_reg[s_tdata[3:0]] <= s_tdata[35:4];
        unique case (state_reg)
            rfd_pkg::ST_IDLE: begin
                v_reg[0] <= s_tdata[67:36];
                v_reg[1] <= s_tdata[99:68];
                v_reg[2] <= s_tdata[131:100];
                row_reg  <= 2'd0;
                col_reg  <= 2'd0;
                sum_reg  <= '0;
                for (int c = 0; c < 3; c++)
                    d_reg[c] <= 54'(signed'(mat_reg[9 + c]));
            end
            rfd_pkg::ST_MUL_LOAD: neg_reg <= ma[31] ^ mb[31];
            rfd_pkg::ST_ACC: begin
                d_reg[col_reg] <= d_reg[col_reg] + 54'(sfloor);
                if (col_reg == 2'd2) begin
                    col_reg <= 2'd0;
                    if (row_reg != 2'd2) row_reg <= row_reg + 2'd1;
                end else col_reg <= col_reg + 2'd1;
            end
            rfd_pkg::ST_SQ_RUN:
                if (mrsp.done) begin
                    sum_reg <= sum_reg + {2'd0, mrsp.prod};
                    if (col_reg != 2'd2) col_reg <= col_reg + 2'd1;
                end
            rfd_pkg::ST_SQRT_RUN:
                if (sq_done)
                    dist_reg <= (sum_reg[65:64] != 2'd0 || sq_root[31]) ? 32'h7FFFFFFF
                                                                      : sq_root;
            rfd_pkg::ST_NUM_RUN:
                if (mrsp.done) num_reg <= mrsp.prod;
            default: ;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = oerr_reg;
    assign m_tdata  = {ow_reg, oz_reg};
endmodule

/* rtl/rfd_checker.sv */
// Port-level checker for radial_fog_depth, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [63:0] m_tdata
);
    // stalled result holds
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // plane error only with a saturated depth
    `CHK_IMPLY(a_err_sat, aclk, aresetn, m_tvalid && m_tuser,
        m_tdata[31:0] == 32'h7FFFFFFF || m_tdata[31:0] == 32'h80000000)
    // a load request never produces a result next cycle from nothing
    `CHK_NEXT(a_load, aclk, aresetn, s_tvalid && s_tready && !s_tuser && !m_tvalid,
        !m_tvalid)
    // distance is never negative in a plane-error result
    `CHK_IMPLY(a_w_pos, aclk, aresetn, m_tvalid && m_tuser, !m_tdata[63])
endmodule

bind radial_fog_depth rfd_checker u_rfd_checker (.aclk, .aresetn, .s_tvalid, .s_tready,
    .s_tuser, .m_tvalid, .m_tready, .m_tuser, .m_tdata);
